// ===== rtl/cmvsd_pkg.sv =====
// shared types, widths and codes for the column statistics block
// no dependencies
package cmvsd_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int CNT_BITS    = 21;
    localparam int SUM_BITS    = 36;
    localparam int SQ_BITS     = 52;
    localparam int D_BITS      = 73;
    localparam int NN_BITS     = 42;
    localparam int SDSQ_BITS   = 48;
    localparam int ROOT_BITS   = 53;
    localparam logic [CNT_BITS-1:0] MAX_COUNT = CNT_BITS'(1048576);

    localparam int ALU_W     = 112;
    localparam int STEP_BITS = $clog2(ALU_W + 1);

    typedef struct packed {
        logic [15:0] sample;
        logic        last;
    } t_in;

    typedef struct packed {
        logic [23:0] mean_q8;
        logic [39:0] variance_q8;
        logic [23:0] stddev_q8;
        logic [25:0] cv_q16;
        logic [20:0] sample_count;
        logic        mean_zero;
        logic        overflowed;
    } t_out;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
        logic    sub;
    } t_alu_cmd;

endpackage

// ===== rtl/cmvsd_acc.sv =====
// running count, sum and sum of squares of the sample stream
// depends on cmvsd_pkg
module cmvsd_acc (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_take,
    input  cmvsd_pkg::t_in                   i_item,
    output logic [cmvsd_pkg::CNT_BITS-1:0]   o_count,
    output logic [cmvsd_pkg::SUM_BITS-1:0]   o_sum,
    output logic [cmvsd_pkg::SQ_BITS-1:0]    o_sq,
    output logic                             o_ovf
);
    import cmvsd_pkg::*;

    logic [CNT_BITS-1:0]    r_count, n_count;
    logic [SUM_BITS-1:0]    r_sum, n_sum;
    logic [SQ_BITS-1:0]     r_sq, n_sq;
    logic                   r_ovf, n_ovf;
    logic [SAMPLE_BITS-1:0] w_s;
    logic [2*SAMPLE_BITS-1:0] w_sq;

    assign w_s  = i_item.sample[SAMPLE_BITS-1:0];
    assign w_sq = w_s * w_s;

    always_comb begin
        n_count = r_count;
        n_sum   = r_sum;
        n_sq    = r_sq;
        n_ovf   = r_ovf;
        if (r_count < MAX_COUNT) begin
            n_count = r_count + CNT_BITS'(1);
            n_sum   = r_sum + SUM_BITS'(w_s);
            n_sq    = r_sq + SQ_BITS'(w_sq);
        end else begin
            n_ovf = 1'b1;
        end
    end

    assign o_count = n_count;
    assign o_sum   = n_sum;
    assign o_sq    = n_sq;
    assign o_ovf   = n_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
            r_sq    <= '0;
            r_ovf   <= 1'b0;
        end else if (i_take) begin
            if (i_item.last) begin
                r_count <= '0;
                r_sum   <= '0;
                r_sq    <= '0;
                r_ovf   <= 1'b0;
            end else begin
                r_count <= n_count;
                r_sum   <= n_sum;
                r_sq    <= n_sq;
                r_ovf   <= n_ovf;
            end
        end
    end

endmodule

// ===== rtl/cmvsd_alu.sv =====
// shared bit-serial unit: shift-add multiply, restoring divide, digit square root
// depends on cmvsd_pkg
module cmvsd_alu (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cmvsd_pkg::t_alu_cmd           i_cmd,
    input  logic [cmvsd_pkg::ALU_W-1:0]   i_acc,
    input  logic [cmvsd_pkg::ALU_W-1:0]   i_a,
    input  logic [cmvsd_pkg::ALU_W-1:0]   i_b,
    input  logic [cmvsd_pkg::ALU_W-1:0]   i_d,
    output logic                          o_busy,
    output logic                          o_done,
    output logic [cmvsd_pkg::ALU_W-1:0]   o_acc,
    output logic [cmvsd_pkg::ALU_W-1:0]   o_a,
    output logic [cmvsd_pkg::ALU_W-1:0]   o_b
);
    import cmvsd_pkg::*;

    logic [ALU_W-1:0]     r_acc, r_a, r_b, r_d;
    logic [STEP_BITS-1:0] r_cnt;
    logic                 r_busy, r_done, r_sub;
    t_alu_op              r_op;

    logic [ALU_W-1:0] w_x, w_y, w_sh;
    logic             w_sub;
    logic [ALU_W:0]   w_sum;
    logic             w_ge;
    logic [STEP_BITS-1:0] w_last;

    always_comb begin
        w_sh  = '0;
        w_x   = r_acc;
        w_y   = r_a;
        w_sub = r_sub;
        case (r_op)
            OP_MUL: begin
                w_x   = r_acc;
                w_y   = r_a;
                w_sub = r_sub;
            end
            OP_DIV: begin
                w_sh  = {r_acc[ALU_W-2:0], r_b[ALU_W-1]};
                w_x   = w_sh;
                w_y   = r_d;
                w_sub = 1'b1;
            end
            OP_SQRT: begin
                w_sh  = {r_acc[ALU_W-3:0], r_b[ALU_W-1:ALU_W-2]};
                w_x   = w_sh;
                w_y   = {r_a[ALU_W-3:0], 2'b01};
                w_sub = 1'b1;
            end
            default: begin
                w_x = r_acc;
            end
        endcase
        w_sum = {1'b0, w_x} + {1'b0, (w_sub ? ~w_y : w_y)} + (ALU_W+1)'(w_sub);
        w_ge  = w_sum[ALU_W];
        w_last = (r_op == OP_SQRT) ? STEP_BITS'(ALU_W / 2 - 1) : STEP_BITS'(ALU_W - 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_op   <= OP_MUL;
            r_sub  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_op   <= i_cmd.op;
                r_sub  <= i_cmd.sub;
                r_acc  <= i_acc;
                r_a    <= i_a;
                r_b    <= i_b;
                r_d    <= i_d;
            end else if (r_busy) begin
                r_cnt <= r_cnt + STEP_BITS'(1);
                if (r_cnt == w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                case (r_op)
                    OP_MUL: begin
                        if (r_b[0]) begin
                            r_acc <= w_sum[ALU_W-1:0];
                        end
                        r_a <= {r_a[ALU_W-2:0], 1'b0};
                        r_b <= {1'b0, r_b[ALU_W-1:1]};
                    end
                    OP_DIV: begin
                        r_acc <= w_ge ? w_sum[ALU_W-1:0] : w_sh;
                        r_b   <= {r_b[ALU_W-2:0], w_ge};
                    end
                    OP_SQRT: begin
                        r_acc <= w_ge ? w_sum[ALU_W-1:0] : w_sh;
                        r_b   <= {r_b[ALU_W-3:0], 2'b00};
                        r_a   <= {r_a[ALU_W-2:0], w_ge};
                    end
                    default: begin
                        r_acc <= r_acc;
                    end
                endcase
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_acc  = r_acc;
    assign o_a    = r_a;
    assign o_b    = r_b;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("done without busy");
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !i_cmd.start |=> r_busy || r_done) else $error("busy dropped without done");
    a_done_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("done while busy");

endmodule

// ===== rtl/column_mean_variance_stddev_cv_top.sv =====
// column statistics top: accumulator, sequencer and result register
// depends on cmvsd_pkg, cmvsd_acc, cmvsd_alu
//
//  channel | valid   | stall   | payload
//  input   | i_valid | o_stall | i_data (t_in)
//  output  | o_valid | i_stall | o_data (t_out)
//
// a non-last sample is added to the sums; samples stream at one per cycle while idle
// a last sample starts eight passes of the shared bit-serial unit (six multiply or
// divide passes and two square-root passes), then the result waits in the output
// register until taken; input is stalled during all of that
// synchronous active-low reset clears the accumulators and the sequencer
module column_mean_variance_stddev_cv_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  cmvsd_pkg::t_in    i_data,
    output logic              o_stall,
    output logic              o_valid,
    output cmvsd_pkg::t_out   o_data,
    input  logic              i_stall
);
    import cmvsd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL_Q, S_MUL_S, S_MUL_N, S_DIV_MEAN,
        S_DIV_SD, S_SQ_SD, S_SQ_CV, S_DIV_CV, S_OUT
    } t_state;

    t_state r_state;
    logic   r_go;

    logic [CNT_BITS-1:0]  r_n;
    logic [SUM_BITS-1:0]  r_s;
    logic [SQ_BITS-1:0]   r_q;
    logic                 r_ovf;
    logic [D_BITS-1:0]    r_dd;
    logic [NN_BITS-1:0]   r_nn;
    logic [SDSQ_BITS-1:0] r_sdsq;
    logic [ROOT_BITS-1:0] r_root;
    t_out                 r_res;

    logic w_take;
    logic [CNT_BITS-1:0] w_count;
    logic [SUM_BITS-1:0] w_sum;
    logic [SQ_BITS-1:0]  w_sq;
    logic                w_ovf;

    t_alu_cmd         w_cmd;
    logic [ALU_W-1:0] w_acc0, w_a0, w_b0, w_d0, w_racc, w_ra, w_rb;
    logic             w_busy, w_done;

    assign o_stall = (r_state != S_IDLE);
    assign w_take  = i_valid && !o_stall;

    cmvsd_acc u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_take),
        .i_item  (i_data),
        .o_count (w_count),
        .o_sum   (w_sum),
        .o_sq    (w_sq),
        .o_ovf   (w_ovf)
    );

    always_comb begin
        w_cmd.start = r_go;
        w_cmd.op    = OP_MUL;
        w_cmd.sub   = 1'b0;
        w_acc0 = '0;
        w_a0   = '0;
        w_b0   = '0;
        w_d0   = '0;
        case (r_state)
            S_MUL_Q: begin
                w_a0 = ALU_W'(r_q);
                w_b0 = ALU_W'(r_n);
            end
            S_MUL_S: begin
                w_cmd.sub = 1'b1;
                w_acc0 = ALU_W'(r_dd);
                w_a0   = ALU_W'(r_s);
                w_b0   = ALU_W'(r_s);
            end
            S_MUL_N: begin
                w_a0 = ALU_W'(r_n);
                w_b0 = ALU_W'(r_n);
            end
            S_DIV_MEAN: begin
                w_cmd.op = OP_DIV;
                w_b0 = ALU_W'({r_s, 8'h00});
                w_d0 = ALU_W'(r_n);
            end
            S_DIV_SD: begin
                w_cmd.op = OP_DIV;
                w_b0 = ALU_W'({r_dd, 16'h0000});
                w_d0 = ALU_W'(r_nn);
            end
            S_SQ_SD: begin
                w_cmd.op = OP_SQRT;
                w_b0 = ALU_W'(r_sdsq);
            end
            S_SQ_CV: begin
                w_cmd.op = OP_SQRT;
                w_b0 = ALU_W'({r_dd, 32'h0000_0000});
            end
            S_DIV_CV: begin
                w_cmd.op = OP_DIV;
                w_b0 = ALU_W'(r_root);
                w_d0 = ALU_W'(r_s);
            end
            default: begin
                w_cmd.start = 1'b0;
            end
        endcase
    end

    cmvsd_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_acc   (w_acc0),
        .i_a     (w_a0),
        .i_b     (w_b0),
        .i_d     (w_d0),
        .o_busy  (w_busy),
        .o_done  (w_done),
        .o_acc   (w_racc),
        .o_a     (w_ra),
        .o_b     (w_rb)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_go    <= 1'b0;
        end else begin
            r_go <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_take && i_data.last) begin
                        r_n     <= w_count;
                        r_s     <= w_sum;
                        r_q     <= w_sq;
                        r_ovf   <= w_ovf;
                        r_state <= S_MUL_Q;
                        r_go    <= 1'b1;
                    end
                end
                S_MUL_Q: begin
                    if (w_done) begin
                        r_dd    <= w_racc[D_BITS-1:0];
                        r_state <= S_MUL_S;
                        r_go    <= 1'b1;
                    end
                end
                S_MUL_S: begin
                    if (w_done) begin
                        r_dd    <= w_racc[D_BITS-1:0];
                        r_state <= S_MUL_N;
                        r_go    <= 1'b1;
                    end
                end
                S_MUL_N: begin
                    if (w_done) begin
                        r_nn    <= w_racc[NN_BITS-1:0];
                        r_state <= S_DIV_MEAN;
                        r_go    <= 1'b1;
                    end
                end
                S_DIV_MEAN: begin
                    if (w_done) begin
                        r_res.mean_q8 <= w_rb[23:0];
                        r_state       <= S_DIV_SD;
                        r_go          <= 1'b1;
                    end
                end
                S_DIV_SD: begin
                    if (w_done) begin
                        r_sdsq            <= w_rb[SDSQ_BITS-1:0];
                        r_res.variance_q8 <= w_rb[47:8];
                        r_state           <= S_SQ_SD;
                        r_go              <= 1'b1;
                    end
                end
                S_SQ_SD: begin
                    if (w_done) begin
                        r_res.stddev_q8 <= w_ra[23:0];
                        r_state         <= S_SQ_CV;
                        r_go            <= 1'b1;
                    end
                end
                S_SQ_CV: begin
                    if (w_done) begin
                        r_root  <= w_ra[ROOT_BITS-1:0];
                        r_state <= S_DIV_CV;
                        r_go    <= 1'b1;
                    end
                end
                S_DIV_CV: begin
                    if (w_done) begin
                        r_res.cv_q16       <= (r_s == '0) ? 26'd0 : w_rb[25:0];
                        r_res.mean_zero    <= (r_s == '0);
                        r_res.sample_count <= r_n;
                        r_res.overflowed   <= r_ovf;
                        r_state            <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!i_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid = (r_state == S_OUT);
    assign o_data  = r_res;

    a_start_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.start |-> r_state != S_IDLE && r_state != S_OUT)
        else $error("unit started outside a compute step");
    a_start_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.start |-> !w_busy) else $error("unit started while busy");
    a_out_after_cv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state) == S_DIV_CV)
        else $error("result shown before last step");
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> o_stall) else $error("input open while computing");

endmodule
